### rtl/integer_set_table_macros.svh
// Assertion macros for the integer set table.
// Used by the top level; needs clk and arst_n in scope.
`ifndef INTEGER_SET_TABLE_MACROS_SVH
`define INTEGER_SET_TABLE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define IST_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define IST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/ist_pkg.sv
// Package for the integer set table: widths, opcodes and the cell command word.
// No dependencies.
package ist_pkg;

	localparam int VALUE_W      = 32;
	localparam int OPCODE_W     = 3;
	localparam int POS_W        = 6;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE = 3'd1,
		OP_FIND   = 3'd2,
		OP_INC    = 3'd3,
		OP_DEC    = 3'd4,
		OP_CLEAR  = 3'd5,
		OP_READ   = 3'd6
	} ist_op_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic compare;   // latch key match for the update step
		logic insert;    // take the left neighbor's entry
		logic remove;    // take the right neighbor's entry at or past the match
		logic inc;       // add one
		logic dec;       // subtract one
	} ist_cmd_t;

endpackage

### rtl/ist_req_if.sv
// Request channel of the integer set table: valid/ready plus request fields.
// Depends on ist_pkg.
interface ist_req_if;
	logic                                valid;
	logic                                ready;
	logic [ist_pkg::OPCODE_W-1:0]        opcode;
	logic signed [ist_pkg::VALUE_W-1:0]  item_value;
	logic [ist_pkg::POS_W-1:0]           position;

	modport source (output valid, opcode, item_value, position, input ready);
	modport sink (input valid, opcode, item_value, position, output ready);
endinterface

### rtl/ist_rsp_if.sv
// Response channel of the integer set table: valid/ready plus result fields.
// Depends on ist_pkg.
interface ist_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                hit;
	logic signed [ist_pkg::VALUE_W-1:0]  entry_value;
	logic                                entry_valid;
	logic                                full_error;
	logic [ist_pkg::COUNT_W-1:0]         count;

	modport source (output valid, hit, entry_value, entry_valid, full_error, count,
		input ready);
	modport sink (input valid, hit, entry_value, entry_valid, full_error, count,
		output ready);
endinterface

### rtl/ist_cell.sv
// One cell of the set row: holds one entry and its latched key match.
// Depends on ist_pkg.
module ist_cell (
	input  logic                                clk,
	input  ist_pkg::ist_cmd_t                   cmd,
	input  logic                                live,
	input  logic signed [ist_pkg::VALUE_W-1:0]  key,
	input  logic signed [ist_pkg::VALUE_W-1:0]  left,
	input  logic signed [ist_pkg::VALUE_W-1:0]  right,
	input  logic                                match_in,
	output logic                                match_out,
	output logic signed [ist_pkg::VALUE_W-1:0]  entry
);

	logic signed [ist_pkg::VALUE_W-1:0] entry_q;
	logic                               match_q;

	assign entry     = entry_q;
	// Carry "a match lies at or before this cell" toward the tail.
	assign match_out = match_in | match_q;

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			match_q <= live && (entry_q == key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			entry_q <= left;
		end else if (cmd.remove && match_out) begin
			entry_q <= right;
		end else if (cmd.inc) begin
			entry_q <= entry_q + 32'sd1;
		end else if (cmd.dec) begin
			entry_q <= entry_q - 32'sd1;
		end
	end

endmodule

### rtl/integer_set_table.sv
// Top level of the integer set table: control, result register, row of cells.
// Depends on ist_pkg, ist_req_if, ist_rsp_if, ist_cell and the macro header.
//
// Usage:
//   req carries one word per request: opcode, item_value and position. rsp
//   returns exactly one word per request: hit, entry_value, entry_valid,
//   full_error and the entry count after the operation.
//   Each request goes through a compare step and then an update step. In the
//   accept cycle every cell compares its entry against item_value and latches
//   the match. The update step runs once the output register is free: the
//   match flags ripple down the cell row, the row shifts, adjusts or holds,
//   and the result word is loaded into the output register. The next request
//   is accepted only after the update step of the current one has run.
//   rsp.valid rises when the update step loads the output register, and the
//   word is taken at a clock edge with rsp.ready high.
//   If the receiver stalls, the result waits in the output register and the
//   pending request holds in the cells until that register frees up.
//   Reset empties the set and drops any pending request or result; the
//   entry storage itself is not cleared.
`include "integer_set_table_macros.svh"

module integer_set_table #(
	parameter int CAPACITY = ist_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ist_req_if.sink   req,
	ist_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > ist_pkg::COUNT_W) ? CW : ist_pkg::COUNT_W;

	logic                                busy_q;
	logic [ist_pkg::OPCODE_W-1:0]        op_s1;
	logic signed [ist_pkg::VALUE_W-1:0]  key_s1;
	logic [ist_pkg::POS_W-1:0]           pos_s1;
	logic [CW-1:0]                       count_q;

	logic                                rsp_valid_q;
	logic                                hit_q;
	logic signed [ist_pkg::VALUE_W-1:0]  value_q;
	logic                                entry_valid_q;
	logic                                full_q;
	logic [ist_pkg::COUNT_W-1:0]         rsp_count_q;

	logic accept;
	logic exec;
	logic hit_all;
	logic set_full;

	ist_pkg::ist_cmd_t cmd;

	logic signed [ist_pkg::VALUE_W-1:0] ent [CAPACITY];
	logic [CAPACITY:0]                  upto;
	logic [CAPACITY-1:0]                live;

	logic                               hit_n;
	logic signed [ist_pkg::VALUE_W-1:0] value_n;
	logic                               entry_valid_n;
	logic                               full_n;
	logic [CW-1:0]                      count_n;
	logic [XW-1:0]                      pos_ext;

	// Handshake: one request in flight at a time.
	assign req.ready = !busy_q;
	assign accept    = req.valid && req.ready;
	assign exec      = busy_q && (!rsp_valid_q || rsp.ready);

	assign hit_all  = upto[CAPACITY];
	assign set_full = (count_q == CW'(CAPACITY));
	assign pos_ext  = XW'(pos_s1);

	// Row of cells. Cell 0 is the newest entry and takes the key on insert.
	assign upto[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [ist_pkg::VALUE_W-1:0] left_w;
		logic signed [ist_pkg::VALUE_W-1:0] right_w;

		assign live[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_w = key_s1;
		end else begin : g_body
			assign left_w = ent[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = ent[i];
		end else begin : g_inner
			assign right_w = ent[i+1];
		end

		ist_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.live      (live[i]),
			.key       (req.item_value),
			.left      (left_w),
			.right     (right_w),
			.match_in  (upto[i]),
			.match_out (upto[i+1]),
			.entry     (ent[i])
		);
	end

	// Hold the request while it executes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= req.opcode;
			key_s1 <= req.item_value;
			pos_s1 <= req.position;
		end
	end

	// Command to the cells: compare on accept, update on execute.
	always_comb begin
		cmd         = '0;
		cmd.compare = accept;
		if (exec) begin
			unique case (ist_pkg::ist_op_t'(op_s1))
				ist_pkg::OP_INSERT: cmd.insert = !hit_all && !set_full;
				ist_pkg::OP_REMOVE: cmd.remove = hit_all;
				ist_pkg::OP_INC:    cmd.inc    = 1'b1;
				ist_pkg::OP_DEC:    cmd.dec    = 1'b1;
				default:            cmd        = cmd;
			endcase
		end
	end

	// Result word and next count.
	always_comb begin
		hit_n         = 1'b0;
		value_n       = '0;
		entry_valid_n = 1'b0;
		full_n        = 1'b0;
		count_n       = count_q;
		unique case (ist_pkg::ist_op_t'(op_s1))
			ist_pkg::OP_INSERT: begin
				hit_n  = hit_all;
				full_n = !hit_all && set_full;
				if (!hit_all && !set_full) begin
					count_n = count_q + CW'(1);
				end
			end
			ist_pkg::OP_REMOVE: begin
				hit_n = hit_all;
				if (hit_all) begin
					count_n = count_q - CW'(1);
				end
			end
			ist_pkg::OP_FIND: hit_n = hit_all;
			ist_pkg::OP_CLEAR: count_n = '0;
			ist_pkg::OP_READ: begin
				entry_valid_n = (pos_ext < XW'(count_q));
				if (entry_valid_n) begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (pos_ext == XW'(i)) begin
							value_n = ent[i];
						end
					end
				end
			end
			default: count_n = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (exec) begin
			count_q <= count_n;
		end
	end

	// Output register: advance on execute, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			hit_q         <= hit_n;
			value_q       <= value_n;
			entry_valid_q <= entry_valid_n;
			full_q        <= full_n;
			rsp_count_q   <= ist_pkg::COUNT_W'(count_n);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = hit_q;
	assign rsp.entry_value = value_q;
	assign rsp.entry_valid = entry_valid_q;
	assign rsp.full_error  = full_q;
	assign rsp.count       = rsp_count_q;

	`IST_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(CAPACITY), "count above capacity")
	`IST_ASSERT_ALWAYS(a_hit_full_excl, !(rsp_valid_q && hit_q && full_q),
		"hit with full_error")
	`IST_ASSERT_NEXT(a_insert_grows, exec && cmd.insert,
		count_q == $past(count_q) + CW'(1), "insert did not grow count")
	`IST_ASSERT_NEXT(a_exec_frees, exec, !busy_q && rsp_valid_q,
		"execute did not complete")

endmodule

### test/integer_set_table_checker.sv
// Checker for the integer set table: mirrors the set, predicts every response
// word and compares it with the word the block returns.
// Depends on ist_pkg, ist_req_if and ist_rsp_if.
`timescale 1ns / 1ps

module integer_set_table_checker
	import ist_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ist_req_if   req,
	ist_rsp_if   rsp,
	output int   fail_count,
	output int   pending_count,
	output int   checked_count,
	output int   hit_count,
	output int   full_count,
	output int   read_count
);

	typedef struct packed {
		logic                 hit;
		logic [VALUE_W-1:0]   entry_value;
		logic                 entry_valid;
		logic                 full_error;
		logic [COUNT_W-1:0]   count;
	} rsp_word_t;

	logic [VALUE_W-1:0] held_entries [CAPACITY];
	int                 held_count;
	rsp_word_t          pending_responses [$];
	rsp_word_t          want;

	// Slot of key among the held entries, -1 when absent.
	function automatic int slot_of(logic [VALUE_W-1:0] key);
		for (int i = 0; i < held_count; i++) begin
			if (held_entries[i] == key) return i;
		end
		return -1;
	endfunction

	// Apply one request to the mirrored set and return the response word it gives.
	function automatic rsp_word_t apply_request(logic [OPCODE_W-1:0] op,
			logic [VALUE_W-1:0] key, logic [POS_W-1:0] pos);
		rsp_word_t w;
		int        at;
		w = '0;
		case (op)
			OP_INSERT: begin
				if (slot_of(key) >= 0) begin
					w.hit = 1'b1;
				end else if (held_count >= CAPACITY) begin
					w.full_error = 1'b1;
				end else begin
					for (int i = held_count; i > 0; i--) held_entries[i] = held_entries[i-1];
					held_entries[0] = key;
					held_count++;
				end
			end
			OP_REMOVE: begin
				at = slot_of(key);
				if (at >= 0) begin
					for (int i = at; i + 1 < held_count; i++) held_entries[i] = held_entries[i+1];
					held_count--;
					w.hit = 1'b1;
				end
			end
			OP_FIND: w.hit = (slot_of(key) >= 0);
			OP_INC: for (int i = 0; i < held_count; i++) held_entries[i] = held_entries[i] + 1'b1;
			OP_DEC: for (int i = 0; i < held_count; i++) held_entries[i] = held_entries[i] - 1'b1;
			OP_CLEAR: held_count = 0;
			OP_READ: begin
				if (int'(pos) < held_count) begin
					w.entry_valid = 1'b1;
					w.entry_value = held_entries[pos];
				end
			end
			default: ;
		endcase
		w.count = COUNT_W'(held_count);
		return w;
	endfunction

	task automatic check_field(string name, logic [VALUE_W-1:0] exp_val,
			logic [VALUE_W-1:0] got_val);
		if (got_val !== exp_val) begin
			$display("t=%0t %s mismatch: expected %0h, actual %0h", $time, name, exp_val,
				got_val);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			pending_responses.delete();
			fail_count = 0;
			pending_count = 0;
			checked_count = 0;
			hit_count = 0;
			full_count = 0;
			read_count = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (pending_responses.size() == 0) begin
					$display("t=%0t response word with none expected: expected nothing, actual %0h",
						$time, {rsp.hit, rsp.entry_value, rsp.entry_valid, rsp.full_error,
						rsp.count});
					fail_count++;
				end else begin
					want = pending_responses.pop_front();
					check_field("hit", want.hit, rsp.hit);
					check_field("entry_value", want.entry_value, rsp.entry_value);
					check_field("entry_valid", want.entry_valid, rsp.entry_valid);
					check_field("full_error", want.full_error, rsp.full_error);
					check_field("count", want.count, rsp.count);
					checked_count++;
					hit_count += want.hit;
					full_count += want.full_error;
					read_count += want.entry_valid;
				end
			end
			if (req.valid && req.ready) begin
				pending_responses.push_back(apply_request(req.opcode, req.item_value,
					req.position));
			end
			pending_count = pending_responses.size();
		end
	end

endmodule

### test/integer_set_table_test.sv
// Testbench top for the integer set table: clock, reset, request stimulus and
// a stalling receiver; the checker beside the block does all prediction.
// Depends on ist_pkg, ist_req_if, ist_rsp_if, integer_set_table and the checker.
`timescale 1ns / 1ps

module integer_set_table_test;
	import ist_pkg::*;

	localparam int CLK_PERIOD_NS  = 2;
	localparam int RESET_CYCLES   = 12;
	localparam int WORDS_TOTAL    = 1050;
	// Receiver hold-off long enough to fill the output register and the cells.
	localparam int RX_HOLD_CYCLES = 300;
	// Idle cycles after the last response before the verdict.
	localparam int SETTLE_CYCLES  = 8;
	// Timeout for the whole run, with a wide margin over the slowest run.
	localparam int RUN_LIMIT_NS   = 800_000;

	// Opcode seven is left unused by the block and must act as a no-op.
	localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n;

	ist_req_if req ();
	ist_rsp_if rsp ();

	int fail_count;
	int pending_count;
	int checked_count;
	int hit_count;
	int full_count;
	int read_count;

	int words_sent;
	int directed_words;
	int burst_left;
	int episode_no;
	bit rx_hold_request;
	int rx_holds_done;
	int rx_mode;
	int rx_mode_left;

	integer_set_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	integer_set_table_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.hit_count     (hit_count),
		.full_count    (full_count),
		.read_count    (read_count)
	);

	always #(CLK_PERIOD_NS / 2) clk = ~clk;

	// Hard stop in case the block hangs a handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Run stopped by timeout at t=%0t", $time);
		$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: hold ready on a pattern whose mode is redrawn at random when its run ends,
	// and honor a request for one long hold-off counted here.
	initial begin
		rsp.ready <= 1'b0;
		rx_mode = 0;
		rx_mode_left = 0;
		rx_holds_done = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_request) begin
				rsp.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_request = 1'b0;
				rx_holds_done++;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_mode_left = $urandom_range(30, 200);
				end
				rx_mode_left--;
				case (rx_mode)
					0: rsp.ready <= 1'b1;                             // never stall
					1: rsp.ready <= $urandom_range(0, 1);             // coin toss
					2: rsp.ready <= ($urandom_range(0, 9) != 0);      // rare stalls
					default: rsp.ready <= ($urandom_range(0, 4) == 0); // mostly stalled
				endcase
			end
		end
	end

	// Drop valid while the sender idles.
	task automatic idle_cycles(int n);
		req.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Present one word and hold it until the block takes it.
	task automatic send_word(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] key,
			logic [POS_W-1:0] pos);
		req.valid <= 1'b1;
		req.opcode <= op;
		req.item_value <= key;
		req.position <= pos;
		do @(posedge clk); while (!req.ready);
		words_sent++;
	endtask

	// Send a word inside the current burst; open a new burst after a gap when
	// the old one runs out. Long bursts give stretches with no idling at all.
	task automatic offer(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] key,
			logic [POS_W-1:0] pos);
		if (burst_left == 0) begin
			idle_cycles($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
		burst_left--;
		send_word(op, key, pos);
	endtask

	// Pause the sender until every expected response word has come back.
	task automatic wait_for_results();
		req.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending_count != 0);
		@(posedge clk);
	endtask

	// Bias read positions toward the low, usually occupied slots.
	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 3) == 0) return POS_W'($urandom_range(0, 63));
		return POS_W'($urandom_range(0, 15));
	endfunction

	// Pick a value window; some windows straddle the signed and unsigned wrap.
	function automatic logic [VALUE_W-1:0] pick_base();
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFC0;
			1: return 32'hFFFF_FFD0;
			default: return $urandom;
		endcase
	endfunction

	// Mixed traffic over a narrow window so inserts, finds and removes collide.
	task automatic run_mix(int n, logic [VALUE_W-1:0] base);
		int                 roll;
		logic [VALUE_W-1:0] key;
		repeat (n) begin
			roll = $urandom_range(0, 99);
			key = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 79);
			if (roll < 32) offer(OP_INSERT, key, pick_position());
			else if (roll < 50) offer(OP_REMOVE, key, pick_position());
			else if (roll < 66) offer(OP_FIND, key, pick_position());
			else if (roll < 84) offer(OP_READ, key, pick_position());
			else if (roll < 90) offer(OP_INC, key, pick_position());
			else if (roll < 96) offer(OP_DEC, key, pick_position());
			else if (roll < 98) offer(OP_CLEAR, key, pick_position());
			else offer(OP_UNUSED, key, pick_position());
		end
	endtask

	// Fill the set past capacity, then work it while full or nearly full.
	task automatic run_fill(logic [VALUE_W-1:0] base);
		int k;
		if ($urandom_range(0, 1)) offer(OP_CLEAR, $urandom, pick_position());
		for (k = 0; k < 70; k++) offer(OP_INSERT, base + k, pick_position());
		for (k = 0; k < 24; k++) begin
			case ($urandom_range(0, 5))
				0: offer(OP_INSERT, base + 200 + k, pick_position());
				1: offer(OP_INSERT, base + $urandom_range(0, 63), pick_position());
				2: offer(OP_READ, $urandom, POS_W'($urandom_range(48, 63)));
				3: offer(OP_FIND, base + $urandom_range(0, 69), pick_position());
				4: offer($urandom_range(0, 1) ? OP_INC : OP_DEC, $urandom, pick_position());
				default: begin
					offer(OP_REMOVE, base + $urandom_range(0, 69), pick_position());
					offer(OP_INSERT, base + 300 + k, pick_position());
				end
			endcase
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req.valid <= 1'b0;
		req.opcode <= OP_INSERT;
		req.item_value <= '0;
		req.position <= '0;
		words_sent = 0;
		burst_left = 0;
		rx_hold_request = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty set: read, remove, find, adjust and clear with nothing held.
		offer(OP_READ, 32'h0, 6'd0);
		offer(OP_REMOVE, 32'h5, 6'd0);
		offer(OP_FIND, 32'h0, 6'd0);
		offer(OP_INC, 32'h0, 6'd0);
		offer(OP_DEC, 32'h0, 6'd0);
		offer(OP_CLEAR, 32'h0, 6'd0);
		// Extreme values, then a duplicate insert.
		offer(OP_INSERT, 32'h7FFF_FFFF, 6'd0);
		offer(OP_INSERT, 32'h8000_0000, 6'd0);
		offer(OP_INSERT, 32'h0, 6'd0);
		offer(OP_INSERT, 32'hFFFF_FFFF, 6'd0);
		offer(OP_INSERT, 32'h7FFF_FFFF, 6'd0);
		// Reads inside, at and beyond the count, and at the top position.
		offer(OP_READ, 32'h0, 6'd0);
		offer(OP_READ, 32'h0, 6'd3);
		offer(OP_READ, 32'h0, 6'd4);
		offer(OP_READ, 32'h0, 6'd63);
		// Increment wraps the largest positive value and minus one.
		offer(OP_INC, 32'h0, 6'd0);
		offer(OP_READ, 32'h0, 6'd3);
		offer(OP_FIND, 32'h0, 6'd0);
		offer(OP_DEC, 32'h0, 6'd0);
		// Remove from the middle, then an absent value.
		offer(OP_REMOVE, 32'h8000_0000, 6'd0);
		offer(OP_REMOVE, 32'h0001_2345, 6'd0);
		offer(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
		offer(OP_READ, 32'h0, 6'd2);
		offer(OP_CLEAR, 32'h0, 6'd0);
		offer(OP_READ, 32'h0, 6'd0);
		directed_words = words_sent;
		wait_for_results();

		episode_no = 0;
		while (words_sent < WORDS_TOTAL) begin
			episode_no++;
			// Stall the receiver for a long stretch while the sender keeps going.
			if (episode_no == 3 || episode_no == 10) rx_hold_request = 1'b1;
			if (episode_no % 4 == 0) run_fill(pick_base());
			else run_mix($urandom_range(20, 80), pick_base());
			if (episode_no % 5 == 2) wait_for_results();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d request words (%0d directed) and %0d checked responses",
			words_sent, directed_words, checked_count);
		$display("with %0d hits, %0d full refusals, %0d valid reads, %0d receiver hold-offs",
			hit_count, full_count, read_count, rx_holds_done);
		if (fail_count == 0 && pending_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
